// ----- hdl/dmkv_pkg.sv -----
// shared types and constants for the direct-mapped key/value table
package dmkv_pkg;

   // field widths
   localparam int KEY_W       = 32;
   localparam int DATA_W      = 32;
   localparam int DUP_W       = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int STEP_W      = 5;
   localparam int REQ_TDATA_W = KEY_W + DATA_W;
   localparam int RSP_TDATA_W = KEY_W + DATA_W + DUP_W;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TABLE_SIZE = 1'b0;

   // table size register
   localparam int SIZE_REG_W = 7;
   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 7'd64;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
   localparam logic [OP_W-1:0] OP_PRINT  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_INSERTED   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_DELETED    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FOUND      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_LISTED     = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd6;

   // control from the sequencer to the slot store
   typedef struct packed {
      logic rd_en;
      logic wr_entry;
      logic wr_valid;
      logic valid_bit;
   } store_ctl_type;

endpackage

// ----- hdl/dmkv_mod_unit.sv -----
// serial remainder unit: key modulo table size, one dividend bit per cycle
module dmkv_mod_unit #(
   parameter int TABLE_DEPTH = 64,
   localparam int SIZE_W = $clog2(TABLE_DEPTH + 1),
   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dmkv_pkg::KEY_W-1:0] dividend,
   input  logic [SIZE_W-1:0]         divisor,
   output logic                      done,
   output logic [SLOT_W-1:0]         remainder
);
   import dmkv_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(KEY_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0]  shift_ff, shift_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   div_ext;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial   = {rem_ff, shift_ff[KEY_W-1]};
   assign div_ext = {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[KEY_W-2:0], 1'b0};
         cnt_in   = cnt_ff + STEP_W'(1);
         if (trial >= div_ext) begin
            rem_in = SIZE_W'(trial - div_ext);
         end else begin
            rem_in = SIZE_W'(trial);
         end
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SLOT_W-1:0];

endmodule

// ----- hdl/dmkv_store.sv -----
// slot store: key/value memory and valid-bit memory on one shared address
module dmkv_store #(
   parameter int TABLE_DEPTH = 64,
   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                        clock,
   input  logic [SLOT_W-1:0]           addr,
   input  dmkv_pkg::store_ctl_type     ctl,
   input  logic [dmkv_pkg::KEY_W-1:0]  wr_key,
   input  logic [dmkv_pkg::DATA_W-1:0] wr_value,
   output logic                        rd_valid,
   output logic [dmkv_pkg::KEY_W-1:0]  rd_key,
   output logic [dmkv_pkg::DATA_W-1:0] rd_value
);
   import dmkv_pkg::*;

   localparam int ENTRY_W = KEY_W + DATA_W;

   logic [ENTRY_W-1:0] entry_mem [TABLE_DEPTH];
   logic               valid_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_entry_ff;
   logic               rd_valid_ff;

   // key/value memory, read data held until the next read
   always_ff @(posedge clock) begin
      if (ctl.wr_entry) begin
         entry_mem[addr] <= {wr_value, wr_key};
      end
      if (ctl.rd_en) begin
         rd_entry_ff <= entry_mem[addr];
      end
   end

   // valid-bit memory
   always_ff @(posedge clock) begin
      if (ctl.wr_valid) begin
         valid_mem[addr] <= ctl.valid_bit;
      end
      if (ctl.rd_en) begin
         rd_valid_ff <= valid_mem[addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_key   = rd_entry_ff[KEY_W-1:0];
   assign rd_value = rd_entry_ff[ENTRY_W-1:KEY_W];

endmodule

// ----- hdl/direct_mapped_key_value_table_unit.sv -----
// Direct-mapped key/value table: top level with sequencer, register port and result register.
// One item is worked on at a time. For insert, delete and find the slot index (key modulo
// the effective table size) comes from a serial remainder unit that retires one key bit per
// cycle, followed by a memory read, the lookup/write-back step and the load of the result
// register. Print walks slots 0 to size-1, reading each slot and then checking it, and gives
// one result per valid slot, or a single list-empty result, waiting on result-side stalls.
// The next item is taken while a finished result still waits in the result register.
// After reset a clearing pass over all TABLE_DEPTH slots zeroes the valid bits; no item is
// taken during it, while register writes are. Table size 0 acts as 1 and sizes above
// TABLE_DEPTH act as TABLE_DEPTH; the duplicate count saturates at all ones.
module direct_mapped_key_value_table_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata fields from bit 0: key[31:0], data_in[31:0]
   input  logic [dmkv_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser fields from bit 0: op[1:0]
   input  logic [dmkv_pkg::OP_W-1:0]        req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata fields from bit 0: key_out[31:0], data_out[31:0], dup_count[31:0]
   output logic [dmkv_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser fields from bit 0: status[2:0]
   output logic [dmkv_pkg::STATUS_W-1:0]    rsp_tuser,
   output logic                             rsp_tlast,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dmkv_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dmkv_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dmkv_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import dmkv_pkg::*;

   localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

   // sequencer states
   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_MOD      = 3'd2;
   localparam logic [2:0] ST_LOOK     = 3'd3;
   localparam logic [2:0] ST_EMIT     = 3'd4;
   localparam logic [2:0] ST_PR_READ  = 3'd5;
   localparam logic [2:0] ST_PR_CHECK = 3'd6;
   localparam logic [2:0] ST_PR_END   = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [SIZE_REG_W-1:0] size_ff;
   logic [SIZE_W-1:0]     size_eff;
   logic [OP_W-1:0]       item_op_ff, item_op_in;
   logic [KEY_W-1:0]      item_key_ff, item_key_in;
   logic [DATA_W-1:0]     item_data_ff, item_data_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [KEY_W-1:0]      pend_key_ff, pend_key_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [DATA_W-1:0]     res_data_ff, res_data_in;
   logic [DUP_W-1:0]      dup_ff, dup_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [KEY_W-1:0]      rsp_key_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [DUP_W-1:0]      rsp_dup_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic                  out_load;
   logic [STATUS_W-1:0]   load_status;
   logic [KEY_W-1:0]      load_key;
   logic [DATA_W-1:0]     load_data;
   logic                  load_last;

   logic                  csr_wr;
   logic                  mod_start;
   logic                  mod_done;
   logic [SLOT_W-1:0]     mod_rem;

   store_ctl_type         st_ctl;
   logic [SLOT_W-1:0]     st_addr;
   logic                  st_rd_valid;
   logic [KEY_W-1:0]      st_rd_key;
   logic [DATA_W-1:0]     st_rd_value;
   logic                  hit;
   logic [SIZE_W-1:0]     idx_next;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_TABLE_SIZE) ?
                       CSR_DATA_W'(size_ff) : '0;

   // effective table size
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (32'(size_ff) > 32'(TABLE_DEPTH)) begin
         size_eff = SIZE_W'(TABLE_DEPTH);
      end else begin
         size_eff = SIZE_W'(size_ff);
      end
   end

   dmkv_mod_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (item_key_in),
      .divisor  (size_eff),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   dmkv_store #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .addr    (st_addr),
      .ctl     (st_ctl),
      .wr_key  (item_key_ff),
      .wr_value(item_data_ff),
      .rd_valid(st_rd_valid),
      .rd_key  (st_rd_key),
      .rd_value(st_rd_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign hit        = st_rd_valid && (st_rd_key == item_key_ff);
   assign idx_next   = SIZE_W'(idx_ff) + SIZE_W'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_op_in    = item_op_ff;
      item_key_in   = item_key_ff;
      item_data_in  = item_data_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_key_in   = pend_key_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      dup_in        = dup_ff;
      st_ctl        = '0;
      st_addr       = idx_ff;
      mod_start     = 1'b0;
      out_load      = 1'b0;
      load_status   = STAT_LISTED;
      load_key      = '0;
      load_data     = '0;
      load_last     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            st_ctl.wr_valid  = 1'b1;
            st_ctl.valid_bit = 1'b0;
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               item_op_in   = req_tuser;
               item_key_in  = req_tdata[KEY_W-1:0];
               item_data_in = req_tdata[REQ_TDATA_W-1:KEY_W];
               if (req_tuser == OP_PRINT) begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_PR_READ;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            st_addr = mod_rem;
            if (mod_done) begin
               st_ctl.rd_en = 1'b1;
               state_in     = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // lookup, write-back and duplicate count in the same cycle
            st_addr     = mod_rem;
            res_data_in = '0;
            state_in    = ST_EMIT;
            unique case (item_op_ff)
               OP_INSERT: begin
                  st_ctl.wr_entry = 1'b1;
                  if (hit) begin
                     res_status_in = STAT_DUPLICATED;
                     if (dup_ff != '1) begin
                        dup_in = dup_ff + DUP_W'(1);
                     end
                  end else begin
                     st_ctl.wr_valid  = 1'b1;
                     st_ctl.valid_bit = 1'b1;
                     res_status_in    = STAT_INSERTED;
                  end
               end
               OP_DELETE: begin
                  if (hit) begin
                     st_ctl.wr_valid  = 1'b1;
                     st_ctl.valid_bit = 1'b0;
                     res_status_in    = STAT_DELETED;
                  end else begin
                     res_status_in = STAT_NOT_FOUND;
                  end
               end
               OP_FIND: begin
                  if (hit) begin
                     res_status_in = STAT_FOUND;
                     res_data_in   = st_rd_value;
                  end else begin
                     res_status_in = STAT_NOT_FOUND;
                  end
               end
               OP_PRINT: begin
                  res_status_in = STAT_NOT_FOUND;
               end
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               load_status = res_status_ff;
               load_data   = res_data_ff;
               load_last   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_PR_READ: begin
            st_ctl.rd_en = 1'b1;
            state_in     = ST_PR_CHECK;
         end
         ST_PR_CHECK: begin
            // a valid slot pushes out the key held from the previous one
            if (!(st_rd_valid && pend_ff && !out_free)) begin
               if (st_rd_valid) begin
                  if (pend_ff) begin
                     out_load    = 1'b1;
                     load_status = STAT_LISTED;
                     load_key    = pend_key_ff;
                  end
                  pend_in     = 1'b1;
                  pend_key_in = st_rd_key;
               end
               if (idx_next == size_eff) begin
                  state_in = ST_PR_END;
               end else begin
                  idx_in   = idx_ff + SLOT_W'(1);
                  state_in = ST_PR_READ;
               end
            end
         end
         ST_PR_END: begin
            if (out_free) begin
               out_load  = 1'b1;
               load_last = 1'b1;
               if (pend_ff) begin
                  load_status = STAT_LISTED;
                  load_key    = pend_key_ff;
               end else begin
                  load_status = STAT_EMPTY;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         dup_ff       <= '0;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_TABLE_SIZE)) begin
            size_ff <= csr_pwdata[SIZE_REG_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_op_ff    <= item_op_in;
      item_key_ff   <= item_key_in;
      item_data_ff  <= item_data_in;
      pend_key_ff   <= pend_key_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (out_load) begin
         rsp_status_ff <= load_status;
         rsp_key_ff    <= load_key;
         rsp_data_ff   <= load_data;
         rsp_dup_ff    <= dup_ff;
         rsp_last_ff   <= load_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dup_ff, rsp_data_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // no item taken during the clearing pass
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("request taken during clearing pass");

   // one item at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken before the first finished");

   // memory writes only from the clearing pass or the lookup cycle
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      st_ctl.wr_valid || st_ctl.wr_entry |-> state_ff == ST_CLEAR || state_ff == ST_LOOK)
      else $error("slot store written outside clear or lookup");

   // duplicate count never goes down
   a_dup_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> dup_ff >= $past(dup_ff))
      else $error("duplicate count decreased");

   // result register never overwritten while a result waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten");

endmodule
